### sv/edsf_pkg.sv
package edsf_pkg;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	typedef struct packed {
		logic [7:0] ch;
		logic       final_byte;
	} src_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       text_end;
	} res_word_t;

endpackage

### sv/escape_decode_space_fold_unit.sv
// Path: an accepted source word is registered in word_s1, and its first result word in out_q.
// Throughput: one source word per cycle while res_ready stays high; a source word that yields two result
// words stalls the input register while its second result word waits in extra_q.
// Reset: arst_n clears all control flags and valid bits asynchronously; the
// decoder flags also return to reset after every word marked final_byte.
module escape_decode_space_fold_unit import edsf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  src_word_t src_word,
	output logic      res_valid,
	input  logic      res_ready,
	output res_word_t res_word
);

	src_word_t word_s1;
	logic      valid_s1;

	logic escape_pending_q;
	logic space_pending_q;
	logic output_started_q;
	logic last_was_ctrl_q;

	res_word_t out_q;
	logic      out_valid_q;
	res_word_t extra_q;
	logic      extra_valid_q;

	logic       load_ok;
	logic       take;
	logic       have;
	logic [7:0] d;
	logic       esc_open;
	logic       is_space;
	logic       is_emit;
	logic       ctrl;
	logic       emit_sp;
	logic       fin;
	logic [7:0] c;
	res_word_t  w0;
	res_word_t  w1;
	logic       has0;

	assign c   = word_s1.ch;
	assign fin = word_s1.final_byte;

	always_comb begin
		have     = 1'b0;
		d        = c;
		esc_open = 1'b0;
		if (escape_pending_q) begin
			have = 1'b1;
			if (c == CH_N) begin
				d = CH_LF;
			end else if (c == CH_T) begin
				d = CH_TAB;
			end else begin
				d = c;
			end
		end else if (c == CH_BACKSLASH) begin
			esc_open = !fin;
			have     = fin;
			d        = CH_BACKSLASH;
		end else if (c == CH_CR || c == CH_LF || c == CH_TAB) begin
			have = 1'b1;
			d    = CH_SPACE;
		end else begin
			have = 1'b1;
			d    = c;
		end
	end

	assign is_space = have && (d == CH_SPACE);
	assign is_emit  = have && (d != CH_SPACE);
	assign ctrl     = (d == CH_LF) || (d == CH_TAB);
	assign emit_sp  = is_emit && space_pending_q && !ctrl;
	assign has0     = is_emit || fin;

	always_comb begin
		w0.out_byte   = 8'h00;
		w0.byte_valid = 1'b0;
		w0.run_last   = 1'b1;
		w0.text_end   = fin;
		if (emit_sp) begin
			w0.out_byte   = CH_SPACE;
			w0.byte_valid = 1'b1;
			w0.run_last   = 1'b0;
			w0.text_end   = 1'b0;
		end else if (is_emit) begin
			w0.out_byte   = d;
			w0.byte_valid = 1'b1;
		end
		w1.out_byte   = d;
		w1.byte_valid = 1'b1;
		w1.run_last   = 1'b1;
		w1.text_end   = fin;
	end

	assign load_ok   = (!out_valid_q || res_ready) && !extra_valid_q;
	assign take      = valid_s1 && load_ok;
	assign src_ready = !valid_s1 || load_ok;
	assign res_valid = out_valid_q;
	assign res_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			word_s1 <= src_word;
		end
	end

	// advance decoder flags when a word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_pending_q <= 1'b0;
			space_pending_q  <= 1'b0;
			output_started_q <= 1'b0;
			last_was_ctrl_q  <= 1'b0;
		end else if (take) begin
			if (fin) begin
				escape_pending_q <= 1'b0;
				space_pending_q  <= 1'b0;
				output_started_q <= 1'b0;
				last_was_ctrl_q  <= 1'b0;
			end else begin
				escape_pending_q <= esc_open;
				if (is_space) begin
					space_pending_q <= output_started_q && !last_was_ctrl_q;
				end else if (is_emit) begin
					space_pending_q  <= 1'b0;
					output_started_q <= 1'b1;
					last_was_ctrl_q  <= ctrl;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			extra_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q   <= has0;
			extra_valid_q <= emit_sp;
		end else if (out_valid_q && res_ready) begin
			out_valid_q   <= extra_valid_q;
			extra_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q   <= w0;
			extra_q <= w1;
		end else if (out_valid_q && res_ready && extra_valid_q) begin
			out_q <= extra_q;
		end
	end

endmodule
